// File: hdl/rcmi_pkg.sv
// Register map, function codes and result type for the RTC counter with match interrupt.
package rcmi_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OFS_W  = 12;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2
	} func_t;

	localparam logic [DATA_W-1:0] RTC_VERSION = 32'h3230_312A;

	// control word bits
	localparam int unsigned CTL_IEN_BIT  = 0;
	localparam int unsigned CTL_MASK_BIT = 1;

	localparam logic [OFS_W-1:0] OFS_COUNT = 12'h000;
	localparam logic [OFS_W-1:0] OFS_MATCH = 12'h004;
	localparam logic [OFS_W-1:0] OFS_LOAD  = 12'h008;
	localparam logic [OFS_W-1:0] OFS_CTRL  = 12'h00C;
	localparam logic [OFS_W-1:0] OFS_STAT  = 12'h010;
	localparam logic [OFS_W-1:0] OFS_RSTAT = 12'h014;
	localparam logic [OFS_W-1:0] OFS_EOI   = 12'h018;
	localparam logic [OFS_W-1:0] OFS_VER   = 12'h01C;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq_out;
	} result_t;

endpackage

// File: hdl/rtc_counter_match_interrupt.sv
// RTC counter with match interrupt: register file, counter and result buffering.
//
// Each item is a tick (func 0), a register read (func 1) or a register write (func 2).
// An item is taken in every cycle in which in_stall is low; its effect on the counter,
// match, load, control and status registers is applied at that edge and its result
// (read_data, irq_out sampled after the item) goes to the result register, or to the
// skid register while that is held. A two-entry output buffer (result register plus
// skid register) keeps the input open while one result waits; in_stall rises only when
// both entries are full. Throughput is one item per cycle while in_stall is low.
module rtc_counter_match_interrupt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [rcmi_pkg::OFS_W-1:0]  reg_offset,
	input  logic [rcmi_pkg::DATA_W-1:0] write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rcmi_pkg::DATA_W-1:0] read_data,
	output logic                        irq_out
);
	import rcmi_pkg::*;

	logic [DATA_W-1:0] count_q, loaded_q, match_q, ctrl_q;
	logic              raw_status_q;

	logic [DATA_W-1:0] count_d, loaded_d, match_d, ctrl_d;
	logic              raw_status_d;
	logic [DATA_W-1:0] count_inc;
	logic              armed_now, armed_next;
	logic              in_accept;
	result_t           res;

	result_t           out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              out_take;

	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	assign count_inc = count_q + 1'b1;
	assign armed_now = ctrl_q[CTL_IEN_BIT] && !ctrl_q[CTL_MASK_BIT];

	always_comb begin
		count_d       = count_q;
		loaded_d      = loaded_q;
		match_d       = match_q;
		ctrl_d        = ctrl_q;
		raw_status_d  = raw_status_q;
		res.read_data = '0;
		unique case (func)
			FUNC_TICK: begin
				count_d = count_inc;
				if (armed_now && count_inc == match_q)
					raw_status_d = 1'b1;
			end
			FUNC_READ: begin
				unique case (reg_offset)
					OFS_COUNT: res.read_data = count_q;
					OFS_MATCH: res.read_data = match_q;
					OFS_LOAD:  res.read_data = loaded_q;
					OFS_CTRL:  res.read_data = ctrl_q;
					OFS_STAT:  res.read_data = DATA_W'(raw_status_q && armed_now);
					OFS_RSTAT: res.read_data = DATA_W'(raw_status_q);
					OFS_EOI:   raw_status_d = 1'b0;
					OFS_VER:   res.read_data = RTC_VERSION;
					default:   res.read_data = '0;
				endcase
			end
			FUNC_WRITE: begin
				unique case (reg_offset)
					OFS_MATCH: match_d = write_data;
					OFS_LOAD: begin
						loaded_d = write_data;
						count_d  = write_data;
					end
					OFS_CTRL:  ctrl_d = write_data;
					default:   ;
				endcase
			end
			default: ;
		endcase
		armed_next  = ctrl_d[CTL_IEN_BIT] && !ctrl_d[CTL_MASK_BIT];
		res.irq_out = raw_status_d && armed_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			loaded_q     <= '0;
			match_q      <= '0;
			ctrl_q       <= '0;
			raw_status_q <= 1'b0;
		end else if (in_accept) begin
			count_q      <= count_d;
			loaded_q     <= loaded_d;
			match_q      <= match_d;
			ctrl_q       <= ctrl_d;
			raw_status_q <= raw_status_d;
		end
	end

	// result register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take)
					skid_valid_q <= 1'b0;
			end else if (in_accept && out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end
			if (out_take)
				out_valid_q <= skid_valid_q || in_accept;
			else if (in_accept)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take)
				out_q <= skid_q;
		end else if (in_accept) begin
			if (out_valid_q && !out_take)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_q.read_data;
	assign irq_out   = out_q.irq_out;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty result register");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid)
		else $error("accepted item produced no result");

	a_status_rise_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(raw_status_q) |-> $past(in_accept && func == FUNC_TICK))
		else $error("status raised by something other than a tick");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_stall) |=> skid_valid_q)
		else $error("skid entry lost while output stalled");
`endif

endmodule
